[design/pft_pkg.sv]
// Shared types for the polygon fan triangulator.
// No dependencies; imported by every module of the block.
`default_nettype none

package pft_pkg;

  // Corners taken for the open polygon, saturating at the fan point.
  typedef enum logic [1:0] {
    CS_NONE = 2'd0,
    CS_ONE  = 2'd1,
    CS_FAN  = 2'd2
  } corner_cnt_t;

  // Per-beat marks that travel with a vertex.
  typedef struct packed {
    logic last_in_polygon;
    logic empty_face;
    logic start_of_mesh;
  } marks_t;

  // Pipeline handshake between the input register, the core and the output register.
  typedef struct packed {
    logic adv;   // output register can take a new value this cycle
    logic fire;  // input register item is consumed this cycle
  } pipe_ctl_t;

endpackage

`default_nettype wire

[design/pft_in_stage.sv]
// Input register of the polygon fan triangulator: holds one accepted beat.
// Depends on pft_pkg for marks_t and pipe_ctl_t.
`default_nettype none

module pft_in_stage #(
  parameter int VIDX_W = 24
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VIDX_W-1:0]      in_vertex_index,
  input  pft_pkg::marks_t        in_marks,
  input  pft_pkg::pipe_ctl_t     ctl,
  output logic                   s1_valid,
  output logic [VIDX_W-1:0]      s1_vertex,
  output pft_pkg::marks_t        s1_marks
);
  import pft_pkg::*;

  logic              valid_r, valid_nxt;
  logic [VIDX_W-1:0] vertex_r;
  marks_t            marks_r;
  logic              take;

  assign in_stall  = valid_r && !ctl.adv;
  assign take      = in_valid && !in_stall;
  assign valid_nxt = take || (valid_r && !ctl.fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      vertex_r <= in_vertex_index;
      marks_r  <= in_marks;
    end
  end

  assign s1_valid  = valid_r;
  assign s1_vertex = vertex_r;
  assign s1_marks  = marks_r;

endmodule

`default_nettype wire

[design/pft_fan_core.sv]
// Fan state and per-vertex step: apex, previous corner and the mesh counters.
// Depends on pft_pkg for corner_cnt_t, marks_t and pipe_ctl_t.
`default_nettype none

module pft_fan_core #(
  parameter int VIDX_W = 24,
  parameter int CNT_W  = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pft_pkg::pipe_ctl_t  ctl,
  input  logic [VIDX_W-1:0]   s1_vertex,
  input  pft_pkg::marks_t     s1_marks,
  output logic                emit,
  output logic [VIDX_W-1:0]   c0_vertex,
  output logic [VIDX_W-1:0]   c1_vertex,
  output logic [VIDX_W-1:0]   c2_vertex,
  output logic [CNT_W-1:0]    c0_offset,
  output logic [CNT_W-1:0]    c1_offset,
  output logic [CNT_W-1:0]    c2_offset,
  output logic [CNT_W-1:0]    poly_id,
  output logic [CNT_W-1:0]    tri_num
);
  import pft_pkg::*;

  corner_cnt_t       cs_r, cs_nxt, cs;
  logic [VIDX_W-1:0] apex_v_r, apex_v_nxt, apex_v;
  logic [VIDX_W-1:0] prev_v_r, prev_v_nxt, prev_v;
  logic [CNT_W-1:0]  apex_o_r, apex_o_nxt, apex_o;
  logic [CNT_W-1:0]  fv_r, fv_nxt, fv;
  logic [CNT_W-1:0]  poly_r, poly_nxt, poly;
  logic [CNT_W-1:0]  tri_r, tri_nxt, tri_c;

  // start of mesh clears everything before the beat is handled
  always_comb begin
    if (s1_marks.start_of_mesh) begin
      cs     = CS_NONE;
      apex_v = '0;
      prev_v = '0;
      apex_o = '0;
      fv     = '0;
      poly   = '0;
      tri_c  = '0;
    end else begin
      cs     = cs_r;
      apex_v = apex_v_r;
      prev_v = prev_v_r;
      apex_o = apex_o_r;
      fv     = fv_r;
      poly   = poly_r;
      tri_c  = tri_r;
    end
  end

  always_comb begin
    cs_nxt     = cs;
    apex_v_nxt = apex_v;
    prev_v_nxt = prev_v;
    apex_o_nxt = apex_o;
    fv_nxt     = fv;
    poly_nxt   = poly;
    tri_nxt    = tri_c;
    emit       = 1'b0;
    if (s1_marks.empty_face) begin
      cs_nxt   = CS_NONE;
      poly_nxt = poly + 1'b1;
    end else begin
      if (cs == CS_NONE) begin
        apex_v_nxt = s1_vertex;
        apex_o_nxt = fv;
      end
      emit       = (cs == CS_FAN);
      tri_nxt    = emit ? tri_c + 1'b1 : tri_c;
      prev_v_nxt = s1_vertex;
      fv_nxt     = fv + 1'b1;
      case (cs)
        CS_NONE: cs_nxt = CS_ONE;
        CS_ONE:  cs_nxt = CS_FAN;
        default: cs_nxt = CS_FAN;
      endcase
      if (s1_marks.last_in_polygon) begin
        cs_nxt   = CS_NONE;
        poly_nxt = poly + 1'b1;
      end
    end
  end

  assign c0_vertex = apex_v;
  assign c1_vertex = prev_v;
  assign c2_vertex = s1_vertex;
  assign c0_offset = apex_o;
  assign c1_offset = fv - 1'b1;
  assign c2_offset = fv;
  assign poly_id   = poly;
  assign tri_num   = tri_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cs_r     <= CS_NONE;
      apex_v_r <= '0;
      prev_v_r <= '0;
      apex_o_r <= '0;
      fv_r     <= '0;
      poly_r   <= '0;
      tri_r    <= '0;
    end else if (ctl.fire) begin
      cs_r     <= cs_nxt;
      apex_v_r <= apex_v_nxt;
      prev_v_r <= prev_v_nxt;
      apex_o_r <= apex_o_nxt;
      fv_r     <= fv_nxt;
      poly_r   <= poly_nxt;
      tri_r    <= tri_nxt;
    end
  end

endmodule

`default_nettype wire

[design/pft_out_stage.sv]
// Result register of the polygon fan triangulator: one triangle beat.
// Depends on pft_pkg for pipe_ctl_t.
`default_nettype none

module pft_out_stage #(
  parameter int VIDX_W = 24,
  parameter int CNT_W  = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               s1_valid,
  input  logic               emit,
  input  logic               out_stall,
  output pft_pkg::pipe_ctl_t ctl,
  input  logic [VIDX_W-1:0]  c0_vertex,
  input  logic [VIDX_W-1:0]  c1_vertex,
  input  logic [VIDX_W-1:0]  c2_vertex,
  input  logic [CNT_W-1:0]   c0_offset,
  input  logic [CNT_W-1:0]   c1_offset,
  input  logic [CNT_W-1:0]   c2_offset,
  input  logic [CNT_W-1:0]   poly_id,
  input  logic [CNT_W-1:0]   tri_num,
  output logic               out_valid,
  output logic [VIDX_W-1:0]  out_corner0_vertex,
  output logic [VIDX_W-1:0]  out_corner1_vertex,
  output logic [VIDX_W-1:0]  out_corner2_vertex,
  output logic [CNT_W-1:0]   out_corner0_offset,
  output logic [CNT_W-1:0]   out_corner1_offset,
  output logic [CNT_W-1:0]   out_corner2_offset,
  output logic [CNT_W-1:0]   out_polygon_id,
  output logic [CNT_W-1:0]   out_triangle_number
);
  import pft_pkg::*;

  logic              valid_r, valid_nxt;
  logic              load;
  logic [VIDX_W-1:0] c0v_r, c1v_r, c2v_r;
  logic [CNT_W-1:0]  c0o_r, c1o_r, c2o_r, pid_r, tnum_r;

  assign ctl.adv  = !valid_r || !out_stall;
  assign ctl.fire = s1_valid && ctl.adv;
  assign load     = ctl.fire && emit;
  assign valid_nxt = ctl.adv ? load : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      c0v_r  <= c0_vertex;
      c1v_r  <= c1_vertex;
      c2v_r  <= c2_vertex;
      c0o_r  <= c0_offset;
      c1o_r  <= c1_offset;
      c2o_r  <= c2_offset;
      pid_r  <= poly_id;
      tnum_r <= tri_num;
    end
  end

  assign out_valid           = valid_r;
  assign out_corner0_vertex  = c0v_r;
  assign out_corner1_vertex  = c1v_r;
  assign out_corner2_vertex  = c2v_r;
  assign out_corner0_offset  = c0o_r;
  assign out_corner1_offset  = c1o_r;
  assign out_corner2_offset  = c2o_r;
  assign out_polygon_id      = pid_r;
  assign out_triangle_number = tnum_r;

endmodule

`default_nettype wire

[design/polygon_fan_triangulator.sv]
// Top level of the polygon fan triangulator: input register, fan core, result register.
// Depends on pft_pkg, pft_in_stage, pft_fan_core and pft_out_stage.
//
//   channel | direction | beat                                    | handshake
//   in_     | input     | vertex index + last/empty/start marks   | in_valid / in_stall
//   out_    | output    | fan triangle: 3 corners, ids, offsets   | out_valid / out_stall
//
// One vertex beat per cycle while in_stall is low; the fan core state updates per consumed beat.
// A triangle is on out_ once its vertex beat has gone from the input register into the result register.
// Synchronous active-low reset clears all counters, the open polygon and both valid flags.
// in_stall rises only while the input register is full and the result register is
// stalled with a pending triangle.
`default_nettype none

module polygon_fan_triangulator #(
  parameter int VERTEX_INDEX_BITS = 24,
  parameter int COUNTER_BITS      = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [VERTEX_INDEX_BITS-1:0] in_vertex_index,
  input  logic                         in_last_in_polygon,
  input  logic                         in_empty_face,
  input  logic                         in_start_of_mesh,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [VERTEX_INDEX_BITS-1:0] out_corner0_vertex,
  output logic [VERTEX_INDEX_BITS-1:0] out_corner1_vertex,
  output logic [VERTEX_INDEX_BITS-1:0] out_corner2_vertex,
  output logic [COUNTER_BITS-1:0]      out_corner0_offset,
  output logic [COUNTER_BITS-1:0]      out_corner1_offset,
  output logic [COUNTER_BITS-1:0]      out_corner2_offset,
  output logic [COUNTER_BITS-1:0]      out_polygon_id,
  output logic [COUNTER_BITS-1:0]      out_triangle_number
);
  import pft_pkg::*;

  marks_t                       in_marks;
  marks_t                       s1_marks;
  pipe_ctl_t                    ctl;
  logic                         s1_valid;
  logic [VERTEX_INDEX_BITS-1:0] s1_vertex;
  logic                         emit;
  logic [VERTEX_INDEX_BITS-1:0] c0_vertex, c1_vertex, c2_vertex;
  logic [COUNTER_BITS-1:0]      c0_offset, c1_offset, c2_offset, poly_id, tri_num;

  assign in_marks.last_in_polygon = in_last_in_polygon;
  assign in_marks.empty_face      = in_empty_face;
  assign in_marks.start_of_mesh   = in_start_of_mesh;

  pft_in_stage #(.VIDX_W(VERTEX_INDEX_BITS)) u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_vertex_index (in_vertex_index),
    .in_marks        (in_marks),
    .ctl             (ctl),
    .s1_valid        (s1_valid),
    .s1_vertex       (s1_vertex),
    .s1_marks        (s1_marks)
  );

  pft_fan_core #(.VIDX_W(VERTEX_INDEX_BITS), .CNT_W(COUNTER_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .s1_vertex (s1_vertex),
    .s1_marks  (s1_marks),
    .emit      (emit),
    .c0_vertex (c0_vertex),
    .c1_vertex (c1_vertex),
    .c2_vertex (c2_vertex),
    .c0_offset (c0_offset),
    .c1_offset (c1_offset),
    .c2_offset (c2_offset),
    .poly_id   (poly_id),
    .tri_num   (tri_num)
  );

  pft_out_stage #(.VIDX_W(VERTEX_INDEX_BITS), .CNT_W(COUNTER_BITS)) u_out (
    .clk                 (clk),
    .rst_n               (rst_n),
    .s1_valid            (s1_valid),
    .emit                (emit),
    .out_stall           (out_stall),
    .ctl                 (ctl),
    .c0_vertex           (c0_vertex),
    .c1_vertex           (c1_vertex),
    .c2_vertex           (c2_vertex),
    .c0_offset           (c0_offset),
    .c1_offset           (c1_offset),
    .c2_offset           (c2_offset),
    .poly_id             (poly_id),
    .tri_num             (tri_num),
    .out_valid           (out_valid),
    .out_corner0_vertex  (out_corner0_vertex),
    .out_corner1_vertex  (out_corner1_vertex),
    .out_corner2_vertex  (out_corner2_vertex),
    .out_corner0_offset  (out_corner0_offset),
    .out_corner1_offset  (out_corner1_offset),
    .out_corner2_offset  (out_corner2_offset),
    .out_polygon_id      (out_polygon_id),
    .out_triangle_number (out_triangle_number)
  );

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid)
    else $error("in_stall with empty input register");

  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result beat without a source vertex");

  a_prev_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_corner1_offset == out_corner2_offset - 1'b1))
    else $error("previous corner offset not one below current");

endmodule

`default_nettype wire

[verif/polygon_fan_triangulator_test.sv]
// Testbench for polygon_fan_triangulator: directed and random vertex streams with random
// idling on both channels, each triangle checked against an in-bench fan predictor.
// Depends on pft_pkg and the polygon_fan_triangulator RTL only.
module polygon_fan_triangulator_test;
  import pft_pkg::*;

  localparam int VB          = 24;
  localparam int CB          = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [VB-1:0] apex_v;
    logic [VB-1:0] prev_v;
    logic [VB-1:0] cur_v;
    logic [CB-1:0] apex_o;
    logic [CB-1:0] prev_o;
    logic [CB-1:0] cur_o;
    logic [CB-1:0] poly;
    logic [CB-1:0] tri_no;
  } fan_tri_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_stall;
  logic [VB-1:0] in_vertex_index;
  logic          in_last_in_polygon;
  logic          in_empty_face;
  logic          in_start_of_mesh;
  logic          out_valid;
  logic          out_stall;
  logic [VB-1:0] out_corner0_vertex;
  logic [VB-1:0] out_corner1_vertex;
  logic [VB-1:0] out_corner2_vertex;
  logic [CB-1:0] out_corner0_offset;
  logic [CB-1:0] out_corner1_offset;
  logic [CB-1:0] out_corner2_offset;
  logic [CB-1:0] out_polygon_id;
  logic [CB-1:0] out_triangle_number;

  // fan predictor state
  corner_cnt_t   fan_corners = CS_NONE;
  logic [VB-1:0] apex_vtx    = '0;
  logic [CB-1:0] apex_off    = '0;
  logic [VB-1:0] prev_vtx    = '0;
  logic [CB-1:0] next_off    = '0;
  logic [CB-1:0] poly_num    = '0;
  logic [CB-1:0] tri_count   = '0;

  fan_tri_t pending_tris[$];

  int  mismatches   = 0;
  int  beats_sent   = 0;
  int  tris_checked = 0;
  int  cycle_count  = 0;
  bit  src_idle     = 1'b1;
  bit  sink_idle    = 1'b1;

  polygon_fan_triangulator #(
    .VERTEX_INDEX_BITS(VB),
    .COUNTER_BITS(CB)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_vertex_index(in_vertex_index),
    .in_last_in_polygon(in_last_in_polygon),
    .in_empty_face(in_empty_face),
    .in_start_of_mesh(in_start_of_mesh),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_corner0_vertex(out_corner0_vertex),
    .out_corner1_vertex(out_corner1_vertex),
    .out_corner2_vertex(out_corner2_vertex),
    .out_corner0_offset(out_corner0_offset),
    .out_corner1_offset(out_corner1_offset),
    .out_corner2_offset(out_corner2_offset),
    .out_polygon_id(out_polygon_id),
    .out_triangle_number(out_triangle_number)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic note_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int draw_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [VB-1:0] draw_vertex();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 10) return '1;
    return VB'($urandom);
  endfunction

  function automatic void fan_predict(input logic [VB-1:0] vidx, input logic last,
                                      input logic empty, input logic start);
    fan_tri_t t;
    logic [CB-1:0] off;
    if (start) begin
      fan_corners = CS_NONE;
      apex_vtx    = '0;
      apex_off    = '0;
      prev_vtx    = '0;
      next_off    = '0;
      poly_num    = '0;
      tri_count   = '0;
    end
    if (empty) begin
      // drops any open polygon
      fan_corners = CS_NONE;
      poly_num    = poly_num + 1'b1;
      return;
    end
    off = next_off;
    if (fan_corners == CS_NONE) begin
      apex_vtx = vidx;
      apex_off = off;
    end
    if (fan_corners == CS_FAN) begin
      t.apex_v = apex_vtx;
      t.prev_v = prev_vtx;
      t.cur_v  = vidx;
      t.apex_o = apex_off;
      t.prev_o = off - 1'b1;
      t.cur_o  = off;
      t.poly   = poly_num;
      t.tri_no = tri_count;
      pending_tris.push_back(t);
      tri_count = tri_count + 1'b1;
    end
    prev_vtx = vidx;
    if (fan_corners != CS_FAN) fan_corners = corner_cnt_t'(fan_corners + 2'd1);
    next_off = next_off + 1'b1;
    if (last) begin
      fan_corners = CS_NONE;
      poly_num    = poly_num + 1'b1;
    end
  endfunction

  task automatic push_beat(input logic [VB-1:0] vidx, input logic last,
                           input logic empty, input logic start);
    int gap;
    gap = draw_gap(src_idle);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_vertex_index    <= vidx;
    in_last_in_polygon <= last;
    in_empty_face      <= empty;
    in_start_of_mesh   <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fan_predict(vidx, last, empty, start);
    beats_sent++;
  endtask

  task automatic match_field(input string name, input logic [CB-1:0] got,
                             input logic [CB-1:0] want);
    if (got !== want)
      note_error($sformatf("triangle %0d %s: got %h, expected %h",
                           tris_checked, name, got, want));
  endtask

  task automatic check_triangle();
    fan_tri_t t;
    if (pending_tris.size() == 0) begin
      note_error("triangle beat with none expected");
      return;
    end
    t = pending_tris.pop_front();
    match_field("corner0_vertex", CB'(out_corner0_vertex), CB'(t.apex_v));
    match_field("corner1_vertex", CB'(out_corner1_vertex), CB'(t.prev_v));
    match_field("corner2_vertex", CB'(out_corner2_vertex), CB'(t.cur_v));
    match_field("corner0_offset", out_corner0_offset, t.apex_o);
    match_field("corner1_offset", out_corner1_offset, t.prev_o);
    match_field("corner2_offset", out_corner2_offset, t.cur_o);
    match_field("polygon_id", out_polygon_id, t.poly);
    match_field("triangle_number", out_triangle_number, t.tri_no);
    tris_checked++;
  endtask

  // result side: check accepted beats, stall at random
  initial begin
    int hold;
    hold      = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) check_triangle();
      if (hold == 0) hold = draw_gap(sink_idle);
      if (hold > 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d triangles outstanding",
             cycle_count, pending_tris.size());
    $display("CHECK FAILED");
    $finish;
  end

  task automatic test_fan_extremes();
    push_beat(24'h000000, 1'b0, 1'b0, 1'b1);
    push_beat(24'hFFFFFF, 1'b0, 1'b0, 1'b0);
    push_beat(24'h800000, 1'b0, 1'b0, 1'b0);
    push_beat(24'h7FFFFF, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_short_polygons();
    push_beat(24'h123456, 1'b1, 1'b0, 1'b0);
    push_beat(24'hABCDEF, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000001, 1'b1, 1'b0, 1'b0);
    push_beat(24'h00000A, 1'b0, 1'b0, 1'b0);
    push_beat(24'h00000B, 1'b0, 1'b0, 1'b0);
    push_beat(24'h00000C, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_empty_faces();
    push_beat(24'hFFFFFF, 1'b1, 1'b1, 1'b0);
    push_beat(24'h000100, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000200, 1'b0, 1'b0, 1'b0);
    push_beat(24'h555555, 1'b0, 1'b1, 1'b0);
    push_beat(24'h000300, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000400, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000500, 1'b1, 1'b0, 1'b0);
  endtask

  task automatic test_start_of_mesh();
    push_beat(24'hAAAAAA, 1'b0, 1'b0, 1'b0);
    push_beat(24'hBBBBBB, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000010, 1'b0, 1'b0, 1'b1);
    push_beat(24'h000020, 1'b0, 1'b0, 1'b0);
    push_beat(24'h000030, 1'b1, 1'b0, 1'b0);
    push_beat(24'hFFFFFF, 1'b1, 1'b1, 1'b1);
  endtask

  // mostly well-formed polygons, with empty faces, mesh restarts and broken polygons
  task automatic run_mesh_stream(input int n_items, input bit toggle_idle);
    int first_beat;
    int corners;
    int r;
    bit restart;
    first_beat = beats_sent;
    while (beats_sent - first_beat < n_items) begin
      if (toggle_idle && $urandom_range(15) == 0) src_idle = !src_idle;
      if (toggle_idle && $urandom_range(15) == 0) sink_idle = !sink_idle;
      r = $urandom_range(99);
      if (r < 6) begin
        push_beat(draw_vertex(), 1'($urandom), 1'b1, $urandom_range(7) == 0);
      end else begin
        r = $urandom_range(99);
        if (r < 10) corners = $urandom_range(1, 2);
        else if (r < 85) corners = $urandom_range(3, 6);
        else corners = $urandom_range(7, 20);
        restart = ($urandom_range(19) == 0);
        for (int k = 0; k < corners; k++) begin
          r = $urandom_range(99);
          if (k > 0 && r < 2) begin
            push_beat(draw_vertex(), 1'($urandom), 1'b1, 1'b0);
            break;
          end
          push_beat(draw_vertex(), k == corners - 1, 1'b0,
                    (k == 0 && restart) || (k > 0 && r == 2));
        end
      end
    end
  endtask

  task automatic test_steady_stream();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    run_mesh_stream(120, 1'b0);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_random_meshes();
    run_mesh_stream(780, 1'b1);
    src_idle  = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_vertex_index    = '0;
    in_last_in_polygon = 1'b0;
    in_empty_face      = 1'b0;
    in_start_of_mesh   = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_fan_extremes();
    test_short_polygons();
    test_empty_faces();
    test_start_of_mesh();
    test_steady_stream();
    test_random_meshes();
    in_valid <= 1'b0;
    while (pending_tris.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("sent %0d vertex beats (polygons, empty faces, mesh restarts)", beats_sent);
    $display("checked %0d fan triangles, %0d mismatches", tris_checked, mismatches);
    if (mismatches == 0 && pending_tris.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
